// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define SERS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define SERS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);

`endif

// ----- rtl/sers_pkg.sv -----
// ----------------------------------------------------------------------------
// sers_pkg
// Types and constants shared by the equal-range search core.
// ----------------------------------------------------------------------------
`default_nettype none

package sers_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int DATA_W    = 32;
	localparam int OUT_IDX_W = 11;

	localparam logic [OUT_IDX_W-1:0] NOT_FOUND = '1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] target;
	} req_t;

	typedef struct packed {
		logic                 valid;
		logic [OUT_IDX_W-1:0] first_index;
		logic [OUT_IDX_W-1:0] last_index;
	} rsp_t;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_equal_range_search_core.sv -----
// ----------------------------------------------------------------------------
// sorted_equal_range_search_core
// Loads an ascending array into on-chip memory and answers equal-range queries.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_axis    in   tdata: value; tuser: kind (0 load, 1 query); tlast: end of array
// m_axis    out  tdata: first_index, last_index (one transfer per query)
//
// A load writes its element as it is taken. A query on an empty array goes straight
// to its result; otherwise the target is checked against the first and the final
// element, then bisection runs, and on a hit the scan moves outward over equal
// neighbors; every probe is one read of the element memory and one compare.
// Reset clears the element count and closes any open array.
// No input is taken while a query runs or waits for room in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_equal_range_search_core #(
	parameter int DEPTH = sers_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [sers_pkg::DATA_W-1:0]   s_axis_tdata,  // value
	input  wire logic                          s_axis_tuser,  // kind
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [23:0]                        m_axis_tdata   // first_index, last_index, pad
);
	import sers_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic signed [DATA_W-1:0]    mem_q [DEPTH];
	logic signed [DATA_W-1:0]    rd_data_q;
	logic [IDX_W-1:0]            rd_addr;

	logic [CNT_W-1:0]            count_q;
	logic                        load_open_q;
	logic [CNT_W-1:0]            cnt_eff;
	logic                        in_xfer;
	logic                        load_xfer;
	logic                        wr_en;
	logic                        busy;
	logic                        rsp_ready;
	req_t                        req;
	rsp_t                        rsp;

	logic                        m_valid_q;
	logic [2*OUT_IDX_W-1:0]      m_data_q;

	always_comb begin
		s_axis_tready = !busy;
		in_xfer       = s_axis_tvalid && s_axis_tready;
		load_xfer     = in_xfer && (s_axis_tuser == KIND_LOAD);
		cnt_eff       = load_open_q ? count_q : '0;
		wr_en         = load_xfer && (cnt_eff < CNT_W'(DEPTH));
		req.start     = in_xfer && (s_axis_tuser == KIND_QUERY);
		req.target    = s_axis_tdata;
		rsp_ready     = !m_valid_q || m_axis_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			load_open_q <= 1'b0;
		end else if (load_xfer) begin
			count_q     <= wr_en ? cnt_eff + CNT_W'(1) : cnt_eff;
			load_open_q <= !s_axis_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cnt_eff[IDX_W-1:0]] <= s_axis_tdata;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	sers_seq #(
		.DEPTH(DEPTH),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.count    (count_q),
		.busy     (busy),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data_q),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (rsp.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.valid) begin
			m_data_q <= {rsp.last_index, rsp.first_index};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_data_q};

endmodule

`default_nettype wire

// ----- rtl/sers_cmp.sv -----
// ----------------------------------------------------------------------------
// sers_cmp
// Shared two's-complement signed comparator of a stored element against the target.
// ----------------------------------------------------------------------------
`default_nettype none

module sers_cmp (
	input  wire logic signed [sers_pkg::DATA_W-1:0] element,
	input  wire logic signed [sers_pkg::DATA_W-1:0] target,
	output sers_pkg::cmp_t                          result
);
	import sers_pkg::*;

	always_comb begin
		result.lt = (element < target);
		result.eq = (element == target);
		result.gt = (element > target);
	end

endmodule

`default_nettype wire

// ----- rtl/sers_seq.sv -----
// ----------------------------------------------------------------------------
// sers_seq
// Query sequencer: bounds checks, bisection and outward scan of equal entries.
// ----------------------------------------------------------------------------
`default_nettype none

module sers_seq #(
	parameter int DEPTH = sers_pkg::DEPTH_DEF,
	parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  sers_pkg::req_t                           req,
	input  wire logic [CNT_W-1:0]                    count,
	output logic                                     busy,
	output logic [IDX_W-1:0]                         rd_addr,
	input  wire logic signed [sers_pkg::DATA_W-1:0]  rd_data,
	input  wire logic                                rsp_ready,
	output sers_pkg::rsp_t                           rsp
);
	import sers_pkg::*;

	localparam int PTR_W = CNT_W + 1;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_RD_LO = 12'b0000_0000_0010,
		S_CK_LO = 12'b0000_0000_0100,
		S_RD_HI = 12'b0000_0000_1000,
		S_CK_HI = 12'b0000_0001_0000,
		S_BS_RD = 12'b0000_0010_0000,
		S_BS_CK = 12'b0000_0100_0000,
		S_SL_RD = 12'b0000_1000_0000,
		S_SL_CK = 12'b0001_0000_0000,
		S_SR_RD = 12'b0010_0000_0000,
		S_SR_CK = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t                    state_q;
	logic signed [DATA_W-1:0]  target_q;
	logic signed [PTR_W-1:0]   left_q;
	logic signed [PTR_W-1:0]   right_q;
	logic [IDX_W-1:0]          mid_q;
	logic [IDX_W-1:0]          a_q;
	logic [IDX_W-1:0]          b_q;
	logic                      hit_q;

	logic [CNT_W-1:0]          cnt_m1;
	logic [CNT_W:0]            sum;
	logic [CNT_W-1:0]          mid;
	logic signed [PTR_W-1:0]   mid_ext;
	logic [IDX_W-1:0]          a_m1;
	logic [CNT_W-1:0]          b_nxt;
	logic [IDX_W+OUT_IDX_W-1:0] a_wide;
	logic [IDX_W+OUT_IDX_W-1:0] b_wide;
	cmp_t                      cmp;

	sers_cmp u_cmp (
		.element(rd_data),
		.target (target_q),
		.result (cmp)
	);

	always_comb begin
		cnt_m1  = count - CNT_W'(1);
		sum     = {1'b0, left_q[CNT_W-1:0]} + {1'b0, right_q[CNT_W-1:0]};
		mid     = sum[CNT_W:1];
		mid_ext = PTR_W'(mid_q);
		a_m1    = a_q - IDX_W'(1);
		b_nxt   = CNT_W'(b_q) + CNT_W'(1);
		a_wide  = {{OUT_IDX_W{1'b0}}, a_q};
		b_wide  = {{OUT_IDX_W{1'b0}}, b_q};
	end

	always_comb begin
		case (state_q)
			S_RD_HI: rd_addr = cnt_m1[IDX_W-1:0];
			S_BS_RD: rd_addr = mid[IDX_W-1:0];
			S_SL_RD: rd_addr = a_m1;
			S_SR_RD: rd_addr = b_nxt[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						if (count == '0) begin
							hit_q   <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD_LO;
						end
					end
				end
				S_RD_LO: state_q <= S_CK_LO;
				S_CK_LO: begin
					if (cmp.gt) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD_HI;
					end
				end
				S_RD_HI: state_q <= S_CK_HI;
				S_CK_HI: begin
					if (cmp.lt) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_BS_RD;
					end
				end
				S_BS_RD: begin
					if (left_q <= right_q) begin
						state_q <= S_BS_CK;
					end else begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_BS_CK: begin
					if (cmp.eq) begin
						state_q <= S_SL_RD;
					end else begin
						state_q <= S_BS_RD;
					end
				end
				S_SL_RD: begin
					if (a_q == '0) begin
						state_q <= S_SR_RD;
					end else begin
						state_q <= S_SL_CK;
					end
				end
				S_SL_CK: begin
					if (cmp.eq) begin
						state_q <= S_SL_RD;
					end else begin
						state_q <= S_SR_RD;
					end
				end
				S_SR_RD: begin
					if (b_nxt >= count) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SR_CK;
					end
				end
				S_SR_CK: begin
					if (cmp.eq) begin
						state_q <= S_SR_RD;
					end else begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				target_q <= req.target;
			end
			S_CK_HI: begin
				left_q  <= '0;
				right_q <= {1'b0, cnt_m1};
			end
			S_BS_RD: begin
				mid_q <= mid[IDX_W-1:0];
			end
			S_BS_CK: begin
				if (cmp.gt) begin
					right_q <= mid_ext - PTR_W'(1);
				end else if (cmp.lt) begin
					left_q <= mid_ext + PTR_W'(1);
				end else begin
					a_q <= mid_q;
					b_q <= mid_q;
				end
			end
			S_SL_CK: begin
				if (cmp.eq) begin
					a_q <= a_m1;
				end
			end
			S_SR_CK: begin
				if (cmp.eq) begin
					b_q <= b_nxt[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		busy            = (state_q != S_IDLE);
		rsp.valid       = (state_q == S_DONE) && rsp_ready;
		rsp.first_index = hit_q ? a_wide[OUT_IDX_W-1:0] : NOT_FOUND;
		rsp.last_index  = hit_q ? b_wide[OUT_IDX_W-1:0] : NOT_FOUND;
	end

endmodule

`default_nettype wire

// ----- rtl/sers_chk.sv -----
// ----------------------------------------------------------------------------
// sers_chk
// Port-level checks of the equal-range search core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sers_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);
	import sers_pkg::*;

	`SERS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`SERS_ASSERT(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[23:22] == 2'b00), "padding bits of result are not zero")
	`SERS_ASSERT(a_miss_pair, !m_axis_tvalid || ((m_axis_tdata[10:0] == NOT_FOUND) == (m_axis_tdata[21:11] == NOT_FOUND)), "only one index reports a miss")
	`SERS_ASSERT(a_order, !m_axis_tvalid || (m_axis_tdata[10:0] == NOT_FOUND) || (m_axis_tdata[10:0] <= m_axis_tdata[21:11]), "first index above last index")
	`SERS_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_QUERY), !s_axis_tready, "input taken right after a query transfer")

endmodule

bind sorted_equal_range_search_core sers_chk u_sers_chk (.*);

`default_nettype wire
